@@ hw/rtl/ert_pkg.sv @@
// Shared types, constants and tables for the rotate-translate point unit.
package ert_pkg;

  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int INT_W    = COORD_W + 2;
  localparam int TRIG_W   = 33;
  localparam int NUM_AXES = 3;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W   = 5;
  localparam int AXIS_W   = 2;

  localparam logic signed [TRIG_W-1:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 33'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;

  // Axis slots in the trig and angle arrays
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_SHIFT_X = 3'd0,
    REG_SHIFT_Y = 3'd1,
    REG_SHIFT_Z = 3'd2,
    REG_ANGLE_X = 3'd3,
    REG_ANGLE_Y = 3'd4,
    REG_ANGLE_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] moved_x;
    logic signed [COORD_W-1:0] moved_y;
    logic signed [COORD_W-1:0] moved_z;
  } out_item_t;

  // Cosine and sine of one angle, Q30
  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // Matrix row pair of one rotation: o1 = u*a + v*b, o2 = u*c + v*d
  typedef struct packed {
    logic signed [TRIG_W-1:0] a;
    logic signed [TRIG_W-1:0] b;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] d;
  } rot_coef_t;

  // Arctangent of 2^-i in Q29
  function automatic logic signed [TRIG_W-1:0] atan_q29(input logic [STEP_W-1:0] i);
    logic signed [TRIG_W-1:0] r;
    unique case (i)
      5'd0:  r = 33'sd421657428;
      5'd1:  r = 33'sd248918915;
      5'd2:  r = 33'sd131521918;
      5'd3:  r = 33'sd66762579;
      5'd4:  r = 33'sd33510843;
      5'd5:  r = 33'sd16771758;
      5'd6:  r = 33'sd8387925;
      5'd7:  r = 33'sd4194219;
      5'd8:  r = 33'sd2097141;
      5'd9:  r = 33'sd1048575;
      default: r = (i <= 5'd29) ? (TRIG_W'(1) <<< (5'd29 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ert_cordic.sv @@
// Iterative CORDIC that turns the three angle registers into cos/sin pairs.
module ert_cordic (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         restart,
  input  logic [ert_pkg::NUM_AXES-1:0][ert_pkg::ANGLE_W-1:0] angles,
  output logic                                         busy,
  output ert_pkg::trig_t [ert_pkg::NUM_AXES-1:0]       trig
);
  import ert_pkg::*;

  typedef enum logic [1:0] {CS_IDLE, CS_LOAD, CS_RUN} cs_state_t;

  cs_state_t                 state_r;
  logic [AXIS_W-1:0]         axis_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [TRIG_W-1:0]  a_r, x_r, y_r;
  logic                      neg_r;
  trig_t [NUM_AXES-1:0]      trig_r;

  logic signed [TRIG_W-1:0]  ang, a_fold, a_nxt, x_nxt, y_nxt, dx, dy, at;
  logic                      neg_fold, last_step;

  // Fold the angle into [-pi/2, pi/2]
  always_comb begin
    ang = TRIG_W'($signed(angles[axis_r]));
    a_fold = ang;
    neg_fold = 1'b0;
    if (ang > HALF_PI_Q29) begin
      a_fold = ang - PI_Q29;
      neg_fold = 1'b1;
    end else if (ang < -HALF_PI_Q29) begin
      a_fold = ang + PI_Q29;
      neg_fold = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = atan_q29(step_r);
    if (!a_r[TRIG_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      a_nxt = a_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      a_nxt = a_r + at;
    end
  end

  assign last_step = (step_r == STEP_W'(CORDIC_STEPS - 1));

  // Sequence the three axes, restart on any angle write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_LOAD;
      axis_r  <= AXIS_X;
      step_r  <= '0;
    end else if (restart) begin
      state_r <= CS_LOAD;
      axis_r  <= AXIS_X;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        CS_IDLE: state_r <= CS_IDLE;
        CS_LOAD: begin
          a_r     <= a_fold;
          neg_r   <= neg_fold;
          x_r     <= GAIN_Q30;
          y_r     <= '0;
          step_r  <= '0;
          state_r <= CS_RUN;
        end
        CS_RUN: begin
          a_r <= a_nxt;
          x_r <= x_nxt;
          y_r <= y_nxt;
          if (last_step) begin
            if (axis_r == AXIS_Z) begin
              state_r <= CS_IDLE;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= CS_LOAD;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: state_r <= CS_IDLE;
      endcase
    end
  end

  // Store the finished pair of the current axis
  always_ff @(posedge clk) begin
    if (state_r == CS_RUN && last_step && !restart) begin
      trig_r[axis_r].c <= neg_r ? -x_nxt : x_nxt;
      trig_r[axis_r].s <= neg_r ? -y_nxt : y_nxt;
    end
  end

  assign busy = (state_r != CS_IDLE);
  assign trig = trig_r;

endmodule

@@ hw/rtl/ert_rot.sv @@
// One plane rotation: a product stage and a rounding-sum stage.
module ert_rot (
  input  logic                                   clk,
  input  logic                                   en_mul,
  input  logic                                   en_sum,
  input  ert_pkg::rot_coef_t                     coef,
  input  logic signed [ert_pkg::INT_W-1:0]       u,
  input  logic signed [ert_pkg::INT_W-1:0]       v,
  input  logic signed [ert_pkg::INT_W-1:0]       w,
  output logic signed [ert_pkg::INT_W-1:0]       o1,
  output logic signed [ert_pkg::INT_W-1:0]       o2,
  output logic signed [ert_pkg::INT_W-1:0]       wo
);
  import ert_pkg::*;

  localparam int PW = INT_W + TRIG_W;
  localparam int SW = PW + 2;

  logic signed [PW-1:0]    ua_r, vb_r, uc_r, vd_r;
  logic signed [INT_W-1:0] w0_r, o1_r, o2_r, w1_r;
  logic signed [SW-1:0]    sum1, sum2;

  // Register the four products
  always_ff @(posedge clk) begin
    if (en_mul) begin
      ua_r <= u * coef.a;
      vb_r <= v * coef.b;
      uc_r <= u * coef.c;
      vd_r <= v * coef.d;
      w0_r <= w;
    end
  end

  // Add, round half up, drop 30 fraction bits
  always_comb begin
    sum1 = SW'(ua_r) + SW'(vb_r) + SW'(HALF_Q30);
    sum2 = SW'(uc_r) + SW'(vd_r) + SW'(HALF_Q30);
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      o1_r <= sum1[30 +: INT_W];
      o2_r <= sum2[30 +: INT_W];
      w1_r <= w0_r;
    end
  end

  assign o1 = o1_r;
  assign o2 = o2_r;
  assign wo = w1_r;

endmodule

@@ hw/rtl/euler_rotate_translate_point_unit.sv @@
// Top level: registers, sin/cos unit, three rotations and the saturating shift.
//
// Moves one 3-D point per transfer: rotate about z, then x, then y, then add
// the shift. Input transfer on in_valid & !in_stall with in_item; result on
// out_valid & !out_stall with out_item. Configuration writes use cfg_wr_en,
// cfg_index and cfg_wdata, taken on the clock edge with no handshake.
// Seven register stages (two per rotation, one for shift and clamp); one point
// per cycle is sustained while out_stall is low and the CORDIC unit is idle.
// After reset and after every angle write, the CORDIC unit runs through the
// three angles (one load and 30 steps each) and in_stall stays high.
// A stall on the result side holds the output register; the stages behind
// it keep filling bubbles, and in_stall rises only once the pipe is full.
// Reset clears the shift and angle registers to zero and empties the pipe.
module euler_rotate_translate_point_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ert_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ert_pkg::out_item_t            out_item,
  input  logic                          cfg_wr_en,
  input  logic [ert_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ert_pkg::CFG_W-1:0]     cfg_wdata
);
  import ert_pkg::*;

  localparam int NSTG = 7;
  localparam int SUM_W = INT_W + 1;
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] MINV = -MAXV - SUM_W'(1);

  logic signed [COORD_W-1:0]             shift_x_r, shift_y_r, shift_z_r;
  logic [NUM_AXES-1:0][ANGLE_W-1:0]      angle_r;
  logic [NSTG-1:0]                       v_r;
  logic [NSTG-1:0]                       en;
  logic                                  busy, restart, in_acc;
  trig_t [NUM_AXES-1:0]                  trig;
  rot_coef_t                             kz, kx, ky;
  logic signed [INT_W-1:0]               px, py, pz;
  logic signed [INT_W-1:0]               zx, zy, zz, xy, xz, xx, yx, yz, yy;
  logic signed [SUM_W-1:0]               sx, sy, sz;
  out_item_t                             out_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      angle_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHIFT_X: shift_x_r <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_Z: shift_z_r <= cfg_wdata[COORD_W-1:0];
        REG_ANGLE_X: angle_r[AXIS_X] <= cfg_wdata[ANGLE_W-1:0];
        REG_ANGLE_Y: angle_r[AXIS_Y] <= cfg_wdata[ANGLE_W-1:0];
        REG_ANGLE_Z: angle_r[AXIS_Z] <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_wr_en && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
                                 cfg_index == REG_ANGLE_Z);

  ert_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .angles  (angle_r),
    .busy    (busy),
    .trig    (trig)
  );

  // Stage enables: a stage advances when empty or when the next one advances
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = busy || !en[0];
  assign in_acc   = in_valid && !in_stall;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_acc;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Rotation coefficients
  always_comb begin
    kz = '{a: trig[AXIS_Z].c, b: -trig[AXIS_Z].s, c: trig[AXIS_Z].s, d: trig[AXIS_Z].c};
    kx = '{a: trig[AXIS_X].c, b: -trig[AXIS_X].s, c: trig[AXIS_X].s, d: trig[AXIS_X].c};
    ky = '{a: trig[AXIS_Y].c, b: trig[AXIS_Y].s, c: -trig[AXIS_Y].s, d: trig[AXIS_Y].c};
  end

  assign px = INT_W'(in_item.point_x);
  assign py = INT_W'(in_item.point_y);
  assign pz = INT_W'(in_item.point_z);

  ert_rot u_rot_z (
    .clk (clk), .en_mul (en[0]), .en_sum (en[1]), .coef (kz),
    .u (px), .v (py), .w (pz), .o1 (zx), .o2 (zy), .wo (zz)
  );

  ert_rot u_rot_x (
    .clk (clk), .en_mul (en[2]), .en_sum (en[3]), .coef (kx),
    .u (zy), .v (zz), .w (zx), .o1 (xy), .o2 (xz), .wo (xx)
  );

  ert_rot u_rot_y (
    .clk (clk), .en_mul (en[4]), .en_sum (en[5]), .coef (ky),
    .u (xx), .v (xz), .w (xy), .o1 (yx), .o2 (yz), .wo (yy)
  );

  // Add shift and clamp to the coordinate range
  always_comb begin
    sx = SUM_W'(yx) + SUM_W'(shift_x_r);
    sy = SUM_W'(yy) + SUM_W'(shift_y_r);
    sz = SUM_W'(yz) + SUM_W'(shift_z_r);
  end

  function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s;
    if (s > MAXV) begin
      t = MAXV;
    end else if (s < MINV) begin
      t = MINV;
    end
    return t[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r.moved_x <= clamp(sx);
      out_r.moved_y <= clamp(sy);
      out_r.moved_z <= clamp(sz);
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_item  = out_r;

endmodule
